// ----- sv/pmqb_pkg.sv -----
`timescale 1ns / 1ps

package pmqb_pkg;

    // default build
    localparam int NUM_QUEUES_DEF  = 4;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int DATA_WIDTH_DEF  = 32;

    // fixed field widths on the stream ports
    localparam int VALUE_W   = 32;
    localparam int QID_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int QID_EXT_W = 8;   // holds any queue count up to 255

    // operation codes carried in s_tuser[0]
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,    // waiting for a word
        ST_DESC,    // descriptor read data valid, update issued
        ST_READ,    // entry read data valid
        ST_RES      // result waits for the output register
    } state_t;

endpackage

// ----- sv/pmqb_desc_mem.sv -----
`timescale 1ns / 1ps

// Queue descriptor store {count, tail, head}; per-entry valid bits make an
// unwritten descriptor read as all zero after reset.
module pmqb_desc_mem #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 13,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/pmqb_entry_mem.sv -----
`timescale 1ns / 1ps

// Shared entry store, one port, registered read.
module pmqb_entry_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic             wr_en,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wr_data,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/partitioned_multi_queue_buffer_unit.sv -----
`timescale 1ns / 1ps
// Flow: a word is accepted in ST_IDLE and its descriptor read; in ST_DESC the descriptor is
//   updated and, on success, the entry memory written (enqueue) or read (dequeue, whose data
//   is valid in ST_READ); the result then waits in ST_RES until the output register is free.
// A new word is accepted only in ST_IDLE, after the previous result has left ST_RES.
// The result sits in an output register; the next word is taken while it waits.
// Reset (aresetn low, synchronous): FSM idle, output empty, all queue
//   descriptors read as empty. Entry store contents are not cleared.
module partitioned_multi_queue_buffer_unit
    import pmqb_pkg::*;
#(
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [VALUE_W-1:0]  s_tdata,    // [31:0] value
    input  logic [7:0]          s_tuser,    // [0] mode, [2:1] queue_id, [7:3] zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [VALUE_W-1:0]  m_tdata,    // [31:0] value_out
    output logic [7:0]          m_tuser     // [1:0] status, [7:2] zero
);

    localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int DDW    = 2 * PW + CW;
    localparam int EDEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int EAW    = $clog2(EDEPTH);

    localparam logic [PW-1:0]        PTR_LAST  = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0]        CNT_FULL  = CW'(QUEUE_DEPTH);
    localparam logic [EAW-1:0]       PART_SIZE = EAW'(QUEUE_DEPTH);
    localparam logic [QID_EXT_W-1:0] NQ_LIM    = QID_EXT_W'(NUM_QUEUES);

    state_t state_reg, state_next;

    // input word decode
    logic                 in_accept;
    logic                 s_mode;
    logic [QID_W-1:0]     s_qid;
    logic [QID_EXT_W-1:0] qid_ext;
    logic                 in_range;
    logic [QW-1:0]        desc_raddr;

    // latched word
    logic               mode_reg;
    logic [QW-1:0]      qidx_reg;
    logic               range_reg;
    logic [VALUE_W-1:0] value_reg;

    // descriptor path
    logic [DDW-1:0] desc_rdata;
    logic [DDW-1:0] desc_wdata;
    logic           desc_we;
    logic [PW-1:0]  head, tail, head_new, tail_new;
    logic [CW-1:0]  count, count_new;
    logic           deq_ok, enq_ok;
    logic [EAW-1:0] part_base, head_slot, tail_slot;

    // entry path
    logic                  ent_we, ent_re;
    logic [EAW-1:0]        ent_addr;
    logic [63:0]           val_ext;
    logic [DATA_WIDTH-1:0] ent_wdata, ent_rdata;
    logic [VALUE_W-1:0]    rd_ext;

    // result
    status_t            status_reg;
    logic               deq_ok_reg;
    logic [VALUE_W-1:0] res_value;
    logic               out_free;
    logic               out_load;
    logic               m_tvalid_reg;
    logic [VALUE_W-1:0] m_data_reg;
    status_t            m_status_reg;

    assign in_accept  = s_tvalid & s_tready;
    assign s_mode     = s_tuser[0];
    assign s_qid      = s_tuser[2:1];
    assign qid_ext    = QID_EXT_W'(s_qid);
    assign in_range   = (qid_ext < NQ_LIM);
    assign desc_raddr = in_range ? qid_ext[QW-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            mode_reg  <= s_mode;
            qidx_reg  <= desc_raddr;
            range_reg <= in_range;
            value_reg <= s_tdata;
        end
    end

    pmqb_desc_mem #(
        .DEPTH (NUM_QUEUES),
        .WIDTH (DDW),
        .AW    (QW)
    ) u_desc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (in_accept),
        .rd_addr (desc_raddr),
        .rd_data (desc_rdata),
        .wr_en   (desc_we),
        .wr_addr (qidx_reg),
        .wr_data (desc_wdata)
    );

    // descriptor fields, valid in ST_DESC
    assign head  = desc_rdata[PW-1:0];
    assign tail  = desc_rdata[2*PW-1:PW];
    assign count = desc_rdata[DDW-1:2*PW];

    // out-of-range queue ids never succeed: empty on dequeue, full on enqueue
    assign deq_ok = range_reg && (mode_reg == MODE_DEQ) && (count != '0);
    assign enq_ok = range_reg && (mode_reg == MODE_ENQ) && (count != CNT_FULL);

    assign head_new  = deq_ok ? ((head == PTR_LAST) ? '0 : head + 1'b1) : head;
    assign tail_new  = enq_ok ? ((tail == PTR_LAST) ? '0 : tail + 1'b1) : tail;
    assign count_new = deq_ok ? count - 1'b1 : count + 1'b1;

    assign desc_we    = (state_reg == ST_DESC) && (deq_ok || enq_ok);
    assign desc_wdata = {count_new, tail_new, head_new};

    // partition base plus in-partition pointer
    assign part_base = EAW'(qidx_reg) * PART_SIZE;
    assign head_slot = part_base + EAW'(head);
    assign tail_slot = part_base + EAW'(tail);

    assign ent_we    = (state_reg == ST_DESC) && enq_ok;
    assign ent_re    = (state_reg == ST_DESC) && deq_ok;
    assign ent_addr  = (mode_reg == MODE_DEQ) ? head_slot : tail_slot;
    assign val_ext   = 64'(value_reg);
    assign ent_wdata = val_ext[DATA_WIDTH-1:0];

    pmqb_entry_mem #(
        .DEPTH (EDEPTH),
        .WIDTH (DATA_WIDTH),
        .AW    (EAW)
    ) u_entry (
        .aclk    (aclk),
        .rd_en   (ent_re),
        .wr_en   (ent_we),
        .addr    (ent_addr),
        .wr_data (ent_wdata),
        .rd_data (ent_rdata)
    );

    // stored bits sign-extended (or truncated, if wider) to the 32-bit result field
    generate
        if (DATA_WIDTH >= VALUE_W) begin : g_rd_trunc
            assign rd_ext = ent_rdata[VALUE_W-1:0];
        end else begin : g_rd_sext
            assign rd_ext = {{(VALUE_W - DATA_WIDTH){ent_rdata[DATA_WIDTH-1]}}, ent_rdata};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DESC) begin
            deq_ok_reg <= deq_ok;
            if (mode_reg == MODE_DEQ) begin
                status_reg <= deq_ok ? STATUS_OK : STATUS_EMPTY;
            end else begin
                status_reg <= enq_ok ? STATUS_OK : STATUS_FULL;
            end
        end
    end

    assign res_value = deq_ok_reg ? rd_ext : '0;
    assign out_free  = !m_tvalid_reg || m_tready;

    // control FSM
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_DESC;
                end
            end
            ST_DESC: begin
                state_next = deq_ok ? ST_READ : ST_RES;
            end
            ST_READ: begin
                state_next = ST_RES;
            end
            ST_RES: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg   <= res_value;
            m_status_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {6'b0, m_status_reg};

    // a non-ok result never carries data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] != STATUS_OK)) |-> (m_tdata == '0))
        else $error("non-ok result with nonzero data");

    // a descriptor never reports more entries than a partition holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DESC) |-> (count <= CNT_FULL))
        else $error("queue occupancy above depth");

    // entry memory is touched only during the descriptor update, for the matching op
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ent_we || ent_re) |-> ((state_reg == ST_DESC) && range_reg && desc_we))
        else $error("entry access outside descriptor update");

    // a word taken moves the FSM to ST_DESC, where s_tready is low and no new word is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (state_reg == ST_DESC) && !s_tready)
        else $error("word accepted while busy");

endmodule

// ----- verif/tb_partitioned_multi_queue_buffer_unit.sv -----
`timescale 1ns / 1ps

module tb_partitioned_multi_queue_buffer_unit;
    import pmqb_pkg::*;

    localparam int QDEPTH      = QUEUE_DEPTH_DEF;
    localparam int NQ          = NUM_QUEUES_DEF;
    localparam int IDX_W       = $clog2(QDEPTH);
    localparam int CNT_W       = $clog2(QDEPTH + 1);
    localparam int RAND_OPS    = 1000;
    localparam int CALM_TAIL   = 120;      // last words go without any idling
    localparam int CYCLE_LIMIT = 200000;

    // one word toward the block
    typedef struct {
        logic             mode;
        logic [QID_W-1:0] qid;
        logic [31:0]      value;
        bit               drain;   // hold this word back until all results are in
    } queue_op_t;

    // one expected result word
    typedef struct {
        logic [31:0] value_out;
        status_t     status;
    } queue_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // [31:0] value
    logic [7:0]  s_tuser  = '0;    // [0] mode, [2:1] queue_id, [7:3] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [31:0] value_out
    logic [7:0]  m_tuser;          // [1:0] status, [7:2] zero

    partitioned_multi_queue_buffer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    queue_op_t     pending_ops[$];
    queue_result_t expected_results[$];
    int            fail_cnt  = 0;
    int            cycle_cnt = 0;
    bit            in_taken  = 1'b0;   // word accepted at the last rising edge
    bit            calm      = 1'b0;   // tail of the run: no idling on either side

    // shadow of the queue state
    logic [31:0]      shadow_slots[NQ*QDEPTH];
    logic [IDX_W-1:0] shadow_head[NQ];
    logic [IDX_W-1:0] shadow_tail[NQ];
    logic [CNT_W-1:0] shadow_fill[NQ];

    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] idx);
        return (int'(idx) == QDEPTH - 1) ? '0 : idx + 1'b1;
    endfunction

    // applies one word to the shadow queues and returns what the block must answer
    function automatic queue_result_t model_queue_op(input logic mode,
                                                     input logic [QID_W-1:0] qid,
                                                     input logic [31:0] value);
        queue_result_t r;
        int            qi;
        int            slot;
        qi          = int'(qid);
        r.value_out = '0;
        r.status    = STATUS_OK;
        if (qi >= NQ) begin
            r.status = (mode == MODE_DEQ) ? STATUS_EMPTY : STATUS_FULL;
        end else if (mode == MODE_DEQ) begin
            if (shadow_fill[qi] == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                slot             = qi * QDEPTH + int'(shadow_head[qi]);
                r.value_out      = shadow_slots[slot];
                shadow_head[qi]  = wrap_idx(shadow_head[qi]);
                shadow_fill[qi]  = shadow_fill[qi] - 1'b1;
            end
        end else begin
            if (int'(shadow_fill[qi]) >= QDEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                slot               = qi * QDEPTH + int'(shadow_tail[qi]);
                shadow_slots[slot] = value;
                shadow_tail[qi]    = wrap_idx(shadow_tail[qi]);
                shadow_fill[qi]    = shadow_fill[qi] + 1'b1;
            end
        end
        return r;
    endfunction

    task automatic add_op(input logic mode, input logic [QID_W-1:0] qid,
                          input logic [31:0] value, input bit drain);
        queue_op_t op;
        op.mode  = mode;
        op.qid   = qid;
        op.value = value;
        op.drain = drain;
        pending_ops.push_back(op);
    endtask

    // random data, with the sign/magnitude extremes mixed in
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic build_stimulus();
        int   n;
        int   seg_len;
        int   enq_pct;
        int   pick;
        bit   one_queue;
        logic [QID_W-1:0] seg_q;
        logic [QID_W-1:0] q;
        logic mode;
        // directed: extremes through queue 0, empty dequeues
        add_op(MODE_ENQ, 2'd0, 32'h8000_0000, 1'b0);
        add_op(MODE_ENQ, 2'd0, 32'h7FFF_FFFF, 1'b0);
        add_op(MODE_DEQ, 2'd3, 32'hFFFF_FFFF, 1'b0);   // never used queue is empty
        add_op(MODE_DEQ, 2'd0, 32'h0, 1'b0);
        add_op(MODE_DEQ, 2'd0, 32'h0, 1'b0);
        add_op(MODE_DEQ, 2'd0, 32'h0, 1'b0);           // drained queue is empty again
        // fill queue 2, then one more is refused as full
        for (int i = 0; i < QDEPTH; i++) begin
            add_op(MODE_ENQ, 2'd2, (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom,
                   1'b0);
        end
        add_op(MODE_ENQ, 2'd2, 32'h1234_5678, 1'b0);
        // free one slot, then refill it at the partition start, where the tail has wrapped
        add_op(MODE_DEQ, 2'd2, 32'h0, 1'b0);
        add_op(MODE_ENQ, 2'd2, 32'hA5A5_5A5A, 1'b0);

        // random: segments with an enqueue share of 20, 50 or 80 percent, mostly on one queue
        n = 0;
        while (n < RAND_OPS) begin
            seg_len   = $urandom_range(5, 40);
            pick      = $urandom_range(0, 2);
            enq_pct   = (pick == 0) ? 20 : (pick == 1) ? 50 : 80;
            one_queue = ($urandom_range(0, 3) != 0);
            seg_q     = QID_W'($urandom_range(0, NQ - 1));
            for (int i = 0; i < seg_len; i++) begin
                q    = one_queue ? seg_q : QID_W'($urandom_range(0, NQ - 1));
                mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
                // first random word always waits for the directed part to drain
                add_op(mode, q, pick_value(),
                       (n == 0) || (i == 0 && $urandom_range(0, 9) == 0));
                n++;
            end
        end
    endtask

    // sender: next word at the falling edge once the previous one was taken
    int        gap_left = 0;
    queue_op_t drv_op;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || in_taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (pending_ops[0].drain && expected_results.size() != 0) begin
                    s_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 4);
                    s_tvalid <= 1'b0;
                end else begin
                    drv_op = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= drv_op.value;
                    s_tuser  <= {5'b0, drv_op.qid, drv_op.mode};
                end
            end
        end
    end

    // receiver: back-pressure in bursts
    int stall_left = 0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // rising edge: predict accepted words, check result words
    queue_result_t mon_exp;
    queue_result_t mon_new;

    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            calm     <= (pending_ops.size() < CALM_TAIL);
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected: value_out %h status %0d",
                           m_tdata, m_tuser[1:0]);
                    fail_cnt++;
                end else begin
                    mon_exp = expected_results.pop_front();
                    if (m_tdata !== mon_exp.value_out) begin
                        $error("value_out: expected %h, actual %h", mon_exp.value_out, m_tdata);
                        fail_cnt++;
                    end
                    if (m_tuser[1:0] !== mon_exp.status) begin
                        $error("status: expected %0d, actual %0d", mon_exp.status,
                               m_tuser[1:0]);
                        fail_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                mon_new = model_queue_op(s_tuser[0], s_tuser[2:1], s_tdata);
                expected_results.push_back(mon_new);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NQ; i++) begin
            shadow_head[i] = '0;
            shadow_tail[i] = '0;
            shadow_fill[i] = '0;
        end
        build_stimulus();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // run until every word went in and every result came back
        @(posedge aclk);
        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);   // catch any stray result word
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/pmqb_pkg.sv
sv/pmqb_desc_mem.sv
sv/pmqb_entry_mem.sv
sv/partitioned_multi_queue_buffer_unit.sv
verif/tb_partitioned_multi_queue_buffer_unit.sv
